// File: hdl/pvl_pkg.sv
// ----------------------------------------------------------------------------
// pvl_pkg
// Shared widths, codes and types for the packed value list.
// ----------------------------------------------------------------------------
package pvl_pkg;

    localparam int DEPTH_DEFAULT = 8;

    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 3;
    localparam int COUNT_W  = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_DUMP   = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_ENTRY    = 3'd4
    } status_t;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                   op;
        logic signed [VALUE_W-1:0]  key;
    } cell_ctl_t;

    // Where a cell sits relative to the current fill level
    typedef struct packed {
        logic occupied;   // position below count
        logic append;     // position equal to count
        logic tail;       // position equal to count - 1
    } slot_t;

endpackage

// File: hdl/pvl_if.sv
// ----------------------------------------------------------------------------
// pvl_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface pvl_req_if import pvl_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           command;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface pvl_rsp_if import pvl_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  entry_value;
    logic [INDEX_W-1:0]         entry_index;
    logic [COUNT_W-1:0]         entry_count;
    logic                       last_flag;

    modport source (output valid, output status, output entry_value,
                    output entry_index, output entry_count, output last_flag,
                    input ready);
    modport sink   (input valid, input status, input entry_value,
                    input entry_index, input entry_count, input last_flag,
                    output ready);
endinterface

// File: hdl/packed_value_list.sv
// ----------------------------------------------------------------------------
// packed_value_list
// Packed list of up to DEPTH signed 32-bit values with insert, delete by
// value and dump, built as a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command word (command, value); rsp carries result words
//   (status, entry_value, entry_index, entry_count, last_flag). A word moves
//   when valid and ready are both high.
//   Insert writes the key to the append slot; delete has every cell compare
//   at once, the cells from the first match up shifting down. The single
//   result word appears in the output register on the next cycle. With
//   rsp.ready held high a new command is taken every cycle. Dump of n
//   entries rotates the chain one place per cycle unless rsp stalls, with
//   the head cell feeding the output: n result words; req.ready stays low
//   while the dump runs. Dump of an empty list gives one empty word. Command
//   code 3 is taken and gives no word.
//   Reset empties the list and drops any pending result. When rsp stalls the
//   output register holds its word and the list waits; no command is taken.
// ----------------------------------------------------------------------------
module packed_value_list import pvl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    pvl_req_if.sink       req,
    pvl_rsp_if.source     rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [IDX_W-1:0]           dump_idx_reg, dump_idx_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    status_t                    status_reg, status_next;
    logic signed [VALUE_W-1:0]  entry_value_reg, entry_value_next;
    logic [INDEX_W-1:0]         entry_index_reg, entry_index_next;
    logic [COUNT_W-1:0]         entry_count_reg, entry_count_next;
    logic                       last_flag_reg, last_flag_next;

    cell_ctl_t                  ctl;
    logic signed [VALUE_W-1:0]  cell_val [DEPTH];
    logic                       found_chain [DEPTH+1];
    logic                       out_free;
    logic                       accept;
    logic                       dump_last;
    logic                       rotate;

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign dump_last = (CNT_W'(dump_idx_reg) == (count_reg - CNT_W'(1)));
    assign rotate    = (state_reg == S_DUMP) && out_free;

    // Broadcast to the chain
    always_comb
    begin
        ctl.key = req.value;
        ctl.op  = CELL_HOLD;
        if (accept)
        begin
            case (cmd_t'(req.command))
                CMD_INSERT:
                begin
                    if (count_reg != FULL_COUNT)
                        ctl.op = CELL_INSERT;
                end
                CMD_DELETE: ctl.op = CELL_DELETE;
                default:    ctl.op = CELL_HOLD;
            endcase
        end
        else if (rotate)
        begin
            ctl.op = CELL_ROTATE;
        end
    end

    assign found_chain[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            slot_t                     slot;
            logic signed [VALUE_W-1:0] upper;

            assign slot.occupied = (CNT_W'(gi) < count_reg);
            assign slot.append   = (CNT_W'(gi) == count_reg);
            assign slot.tail     = (CNT_W'(gi) == (count_reg - CNT_W'(1)));

            if (gi == DEPTH - 1)
            begin : g_top
                assign upper = '0;
            end
            else
            begin : g_mid
                assign upper = cell_val[gi+1];
            end

            pvl_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .slot      (slot),
                .found_in  (found_chain[gi]),
                .upper_val (upper),
                .head_val  (cell_val[0]),
                .found_out (found_chain[gi+1]),
                .val       (cell_val[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        dump_idx_next    = dump_idx_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        status_next      = status_reg;
        entry_value_next = entry_value_reg;
        entry_index_next = entry_index_reg;
        entry_count_next = entry_count_reg;
        last_flag_next   = last_flag_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    entry_value_next = '0;
                    entry_index_next = '0;
                    entry_count_next = COUNT_W'(count_reg);
                    last_flag_next   = 1'b1;
                    case (cmd_t'(req.command))
                        CMD_INSERT:
                        begin
                            rsp_valid_next = 1'b1;
                            if (count_reg == FULL_COUNT)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next      = ST_DONE;
                                count_next       = count_reg + CNT_W'(1);
                                entry_count_next = COUNT_W'(count_reg + CNT_W'(1));
                            end
                        end
                        CMD_DELETE:
                        begin
                            rsp_valid_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (found_chain[DEPTH])
                            begin
                                status_next      = ST_DONE;
                                count_next       = count_reg - CNT_W'(1);
                                entry_count_next = COUNT_W'(count_reg - CNT_W'(1));
                            end
                            else
                            begin
                                status_next = ST_NOTFOUND;
                            end
                        end
                        CMD_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_valid_next = 1'b1;
                                status_next    = ST_EMPTY;
                            end
                            else
                            begin
                                state_next    = S_DUMP;
                                dump_idx_next = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    // emit the head, the chain rotates under it
                    rsp_valid_next   = 1'b1;
                    status_next      = ST_ENTRY;
                    entry_value_next = cell_val[0];
                    entry_index_next = INDEX_W'(dump_idx_reg);
                    entry_count_next = COUNT_W'(count_reg);
                    last_flag_next   = dump_last;
                    dump_idx_next    = dump_idx_reg + IDX_W'(1);
                    if (dump_last)
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            dump_idx_reg    <= '0;
            rsp_valid_reg   <= 1'b0;
            status_reg      <= ST_DONE;
            entry_value_reg <= '0;
            entry_index_reg <= '0;
            entry_count_reg <= '0;
            last_flag_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            dump_idx_reg    <= dump_idx_next;
            rsp_valid_reg   <= rsp_valid_next;
            status_reg      <= status_next;
            entry_value_reg <= entry_value_next;
            entry_index_reg <= entry_index_next;
            entry_count_reg <= entry_count_next;
            last_flag_reg   <= last_flag_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.entry_value = entry_value_reg;
    assign rsp.entry_index = entry_index_reg;
    assign rsp.entry_count = entry_count_reg;
    assign rsp.last_flag   = last_flag_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("list count above depth");

    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DUMP |-> count_reg != '0)
        else $error("dump running on an empty list");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.command == CMD_INSERT && count_reg != FULL_COUNT)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the list");

    a_dump_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (rotate && dump_last) |=> (state_reg == S_IDLE && rsp_valid_reg && last_flag_reg))
        else $error("dump did not close with a last word");

    a_dump_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DUMP |-> (!req.ready && ctl.op != CELL_DELETE))
        else $error("command taken during dump");

endmodule

// File: hdl/pvl_cell.sv
// ----------------------------------------------------------------------------
// pvl_cell
// One list slot: holds a value, compares it with the key, takes the key on
// insert at the append slot and its upper neighbor's value on delete and on dump rotation (the tail takes the head's).
// ----------------------------------------------------------------------------
module pvl_cell import pvl_pkg::*;
(
    input  logic                       clk,
    input  cell_ctl_t                  ctl,
    input  slot_t                      slot,
    input  logic                       found_in,
    input  logic signed [VALUE_W-1:0]  upper_val,
    input  logic signed [VALUE_W-1:0]  head_val,
    output logic                       found_out,
    output logic signed [VALUE_W-1:0]  val
);

    logic signed [VALUE_W-1:0] val_reg;
    logic signed [VALUE_W-1:0] val_next;
    logic                      match;

    assign match     = slot.occupied && (val_reg == ctl.key);
    assign found_out = found_in || match;
    assign val       = val_reg;

    always_comb
    begin
        val_next = val_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                if (slot.append)
                    val_next = ctl.key;
            end
            CELL_DELETE:
            begin
                // close the gap at and above the first match
                if (found_out)
                    val_next = upper_val;
            end
            CELL_ROTATE:
            begin
                // the last occupied cell wraps the head around
                if (slot.tail)
                    val_next = head_val;
                else if (slot.occupied)
                    val_next = upper_val;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule
